// ===== src/assert_macros.svh =====
// assertion macros shared by the tilt bubble overlay rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/tbso_pkg.sv =====
// shared constants, types and helpers of the tilt bubble overlay
// no dependencies
package tbso_pkg;

   localparam int DISPLAY_COLS  = 128;
   localparam int DISPLAY_PAGES = 8;
   localparam int DISPLAY_ROWS  = DISPLAY_PAGES * 8;
   localparam int FRAME_BYTES   = DISPLAY_COLS * DISPLAY_PAGES;

   localparam int COL_W  = $clog2(DISPLAY_COLS);
   localparam int PAGE_W = $clog2(DISPLAY_PAGES);
   localparam int ROW_W  = $clog2(DISPLAY_ROWS);
   localparam int ADDR_W = $clog2(FRAME_BYTES);

   // crosshair background
   localparam int BG_COL  = DISPLAY_COLS / 2;
   localparam int BG_PAGE = (DISPLAY_ROWS / 2) / 8;
   localparam int BG_BIT  = (DISPLAY_ROWS / 2) % 8;

   localparam logic [7:0] SPRITE_COLS [8] = '{
      8'h3C, 8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E, 8'h3C
   };

   typedef struct packed {
      logic [COL_W-1:0]  left;
      logic [COL_W-1:0]  right;
      logic [PAGE_W-1:0] first_page;
      logic [PAGE_W-1:0] last_page;
      logic              sprite_en;
      logic [COL_W-1:0]  sprite_col;   // left column of the sprite box
      logic [ROW_W-1:0]  sprite_row;   // top row of the sprite box
   } sweep_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sweep_stat_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   function automatic logic [ADDR_W-1:0] frame_addr(input logic [COL_W-1:0] col,
                                                    input logic [PAGE_W-1:0] page);
      return ADDR_W'(page) * ADDR_W'(DISPLAY_COLS) + ADDR_W'(col);
   endfunction

endpackage

// ===== src/tbso_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module tbso_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tbso_tilt_map.sv =====
// maps tilt and zero offsets (signed q8.8 degrees) to a clamped bubble centre
// depends on tbso_pkg
module tbso_tilt_map (
   input  logic signed [16:0]          tilt_x,
   input  logic signed [16:0]          tilt_y,
   input  logic signed [16:0]          zero_x,
   input  logic signed [16:0]          zero_y,
   output logic [tbso_pkg::COL_W-1:0]  center_col,
   output logic [tbso_pkg::ROW_W-1:0]  center_row
);

   localparam logic signed [20:0] X_MID = 21'(tbso_pkg::DISPLAY_COLS / 2 * 256);
   localparam logic signed [20:0] Y_MID = 21'(tbso_pkg::DISPLAY_ROWS / 2 * 256);
   localparam logic signed [20:0] LO    = 21'(4 * 256);
   localparam logic signed [20:0] X_HI  = 21'((tbso_pkg::DISPLAY_COLS - 5) * 256);
   localparam logic signed [20:0] Y_HI  = 21'((tbso_pkg::DISPLAY_ROWS - 5) * 256);

   logic signed [17:0] dx;
   logic signed [17:0] dy;
   logic signed [20:0] tx;
   logic signed [20:0] ty;
   logic signed [20:0] tx_c;
   logic signed [20:0] ty_c;

   always_comb begin
      dx = $signed({tilt_x[16], tilt_x}) - $signed({zero_x[16], zero_x});
      dy = $signed({tilt_y[16], tilt_y}) - $signed({zero_y[16], zero_y});
      tx = X_MID + $signed({{2{dx[17]}}, dx, 1'b0});
      ty = Y_MID - $signed({{2{dy[17]}}, dy, 1'b0});

      if (tx < LO)        tx_c = LO;
      else if (tx > X_HI) tx_c = X_HI;
      else                tx_c = tx;

      if (ty < LO)        ty_c = LO;
      else if (ty > Y_HI) ty_c = Y_HI;
      else                ty_c = ty;
   end

   // clamped values are positive, so taking the integer bits truncates
   assign center_col = tx_c[8 +: tbso_pkg::COL_W];
   assign center_row = ty_c[8 +: tbso_pkg::ROW_W];

endmodule

// ===== src/tbso_sweep.sv =====
// walks a box of frame bytes one per cycle and writes background or'd with sprite
// depends on tbso_pkg
module tbso_sweep (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tbso_pkg::sweep_cmd_type  cmd,
   output tbso_pkg::sweep_stat_type stat,
   output tbso_pkg::ram_wr_type     wr
);

   logic                          busy_ff;
   logic [tbso_pkg::COL_W-1:0]    col_ff;
   logic [tbso_pkg::PAGE_W-1:0]   page_ff;
   tbso_pkg::sweep_cmd_type       cmd_ff;

   logic                          last_col;
   logic                          last_page;
   logic [7:0]                    bg;
   logic [7:0]                    spr;
   logic [7:0]                    spr_col;
   logic [tbso_pkg::COL_W-1:0]    col_off;
   logic signed [tbso_pkg::ROW_W+1:0] row_off;
   logic signed [tbso_pkg::ROW_W+1:0] row_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && last_col && last_page) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff  <= cmd;
         col_ff  <= cmd.left;
         page_ff <= cmd.first_page;
      end else if (busy_ff) begin
         if (last_col) begin
            col_ff  <= cmd_ff.left;
            page_ff <= page_ff + tbso_pkg::PAGE_W'(1);
         end else begin
            col_ff <= col_ff + tbso_pkg::COL_W'(1);
         end
      end
   end

   assign last_col  = (col_ff == cmd_ff.right);
   assign last_page = (page_ff == cmd_ff.last_page);

   always_comb begin
      bg = 8'h00;
      if (32'(col_ff) == tbso_pkg::BG_COL) bg = 8'hFF;
      if (32'(page_ff) == tbso_pkg::BG_PAGE) bg[tbso_pkg::BG_BIT] = 1'b1;

      col_off = col_ff - cmd_ff.sprite_col;
      spr_col = 8'h00;
      if (cmd_ff.sprite_en && col_ff >= cmd_ff.sprite_col &&
          32'(col_off) < 8) begin
         spr_col = tbso_pkg::SPRITE_COLS[col_off[2:0]];
      end

      // sprite row offset against the top row of this page
      row_off = $signed({2'b00, cmd_ff.sprite_row}) - $signed({2'b00, page_ff, 3'b000});
      row_neg = -row_off;
      if (row_off >= 0 && row_off < 8) begin
         spr = spr_col << row_off[2:0];
      end else if (row_off < 0 && row_off > -8) begin
         spr = spr_col >> row_neg[2:0];
      end else begin
         spr = 8'h00;
      end
   end

   assign wr.en   = busy_ff;
   assign wr.addr = tbso_pkg::frame_addr(col_ff, page_ff);
   assign wr.data = bg | spr;

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && last_col && last_page;

endmodule

// ===== src/tilt_bubble_sprite_overlay.sv =====
// top level of the tilt bubble overlay on a 1-bit page-layout frame store
// depends on tbso_pkg, tbso_ram, tbso_tilt_map, tbso_sweep, assert_macros.svh
// usage:
//   req channel carries one word per item; req_tuser selects the kind:
//   0 updates the bubble from tilt and zero angles, 1 reads one frame byte.
//   rsp channel returns exactly one word per req word, in order.
//   csr channel writes refresh_interval (minimum ticks between redraws);
//   write it only while the block is idle. csr_ready is always high.
// steps, from the accept edge to rsp_tvalid high:
//   read item: read, done; update with no redraw: map, box, done; update
//   that redraws: map, box, sweep of pages * columns of the dirty box, the
//   sweep writing one frame byte per cycle (at most 1016 bytes), then done
//   one item is in work at a time; req_tready comes back at the edge that
//   loads the response, so the next word can be taken in the cycle after
// reset:
//   synchronous, active high. afterwards a clearing pass writes the
//   crosshair background into all 1024 frame bytes, during which
//   req_tready stays low; csr writes are taken throughout
// stall:
//   when rsp_tready is low the response holds; the block finishes one more
//   item and then waits with req_tready low until the output frees
`include "assert_macros.svh"

module tilt_bubble_sprite_overlay (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // tilt_x[16:0], tilt_y[33:17], zero_x[50:34], zero_y[67:51],
   // now_tick[99:68], read_column[106:100], read_page[109:107], zero pad
   input  logic [111:0] req_tdata,
   // func[0]
   input  logic         req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // dirty_column[6:0], dirty_width[14:7], dirty_first_page[17:15],
   // dirty_last_page[20:18], frame_byte[28:21], zero pad
   output logic [31:0]  rsp_tdata,
   // redrawn[0]
   output logic         rsp_tuser,

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   localparam int COL_W  = tbso_pkg::COL_W;
   localparam int ROW_W  = tbso_pkg::ROW_W;
   localparam int PAGE_W = tbso_pkg::PAGE_W;

   // sequencer states
   localparam logic [2:0] ST_CLR_GO  = 3'd0;
   localparam logic [2:0] ST_CLR_RUN = 3'd1;
   localparam logic [2:0] ST_IDLE    = 3'd2;
   localparam logic [2:0] ST_READ    = 3'd3;
   localparam logic [2:0] ST_MAP     = 3'd4;
   localparam logic [2:0] ST_BOX     = 3'd5;
   localparam logic [2:0] ST_SWEEP   = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   logic [2:0]  state_ff;
   logic [2:0]  state_in;

   // request fields
   logic signed [16:0] f_tilt_x, f_tilt_y, f_zero_x, f_zero_y;
   logic [31:0]        f_now;
   logic [6:0]         f_col;
   logic [2:0]         f_page;

   assign f_tilt_x = req_tdata[16:0];
   assign f_tilt_y = req_tdata[33:17];
   assign f_zero_x = req_tdata[50:34];
   assign f_zero_y = req_tdata[67:51];
   assign f_now    = req_tdata[99:68];
   assign f_col    = req_tdata[106:100];
   assign f_page   = req_tdata[109:107];

   // captured item
   logic signed [16:0] tilt_x_ff, tilt_y_ff, zero_x_ff, zero_y_ff;
   logic [31:0]        now_ff;
   logic               rd_hit_ff;

   // bubble state and config
   logic [COL_W-1:0]   bubble_col_ff;
   logic [ROW_W-1:0]   bubble_row_ff;
   logic [31:0]        last_tick_ff;
   logic [15:0]        refresh_interval_ff;

   // mapped center
   logic [COL_W-1:0]   map_col;
   logic [ROW_W-1:0]   map_row;
   logic [COL_W-1:0]   ncol_ff;
   logic [ROW_W-1:0]   nrow_ff;
   logic               redraw_ff;
   logic [31:0]        elapsed;

   // pending result
   logic               res_redrawn_ff;
   logic [6:0]         res_col_ff;
   logic [7:0]         res_width_ff;
   logic [2:0]         res_first_ff;
   logic [2:0]         res_last_ff;
   logic [7:0]         res_byte_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_redrawn_ff;
   logic [28:0]        rsp_data_ff;
   logic               rsp_load;

   // union box of old and new bubble
   logic [COL_W-1:0]   lo_col, hi_col, box_left, box_right;
   logic [COL_W:0]     right_wide;
   logic [ROW_W-1:0]   lo_row, hi_row, box_top, box_bottom;
   logic [COL_W:0]     box_width;

   // sweep and ram
   logic                     sweep_start;
   logic                     sweep_state;
   tbso_pkg::sweep_cmd_type  sweep_cmd;
   tbso_pkg::sweep_cmd_type  box_cmd;
   tbso_pkg::sweep_cmd_type  clr_cmd;
   tbso_pkg::sweep_stat_type sweep_stat;
   tbso_pkg::ram_wr_type     ram_wr;
   logic                     ram_rd_en;
   logic [tbso_pkg::ADDR_W-1:0] ram_rd_addr;
   logic [7:0]               ram_rd_data;

   logic req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_interval_ff <= 16'd30;
      end else if (csr_valid && csr_ready) begin
         refresh_interval_ff <= csr_data;
      end
   end

   tbso_tilt_map u_map (
      .tilt_x     (tilt_x_ff),
      .tilt_y     (tilt_y_ff),
      .zero_x     (zero_x_ff),
      .zero_y     (zero_y_ff),
      .center_col (map_col),
      .center_row (map_row)
   );

   assign elapsed = now_ff - last_tick_ff;

   always_comb begin
      lo_col     = (bubble_col_ff < ncol_ff) ? bubble_col_ff : ncol_ff;
      hi_col     = (bubble_col_ff > ncol_ff) ? bubble_col_ff : ncol_ff;
      lo_row     = (bubble_row_ff < nrow_ff) ? bubble_row_ff : nrow_ff;
      hi_row     = (bubble_row_ff > nrow_ff) ? bubble_row_ff : nrow_ff;
      box_left   = lo_col - COL_W'(4);
      right_wide = {1'b0, hi_col} + (COL_W+1)'(3);
      // keep the right edge inside the frame
      if (32'(right_wide) >= tbso_pkg::DISPLAY_COLS) begin
         box_right = COL_W'(tbso_pkg::DISPLAY_COLS - 1);
      end else begin
         box_right = right_wide[COL_W-1:0];
      end
      box_top    = lo_row - ROW_W'(4);
      box_bottom = hi_row + ROW_W'(3);
      box_width  = {1'b0, box_right} - {1'b0, box_left} + (COL_W+1)'(1);

      box_cmd.left       = box_left;
      box_cmd.right      = box_right;
      box_cmd.first_page = box_top[ROW_W-1:3];
      box_cmd.last_page  = box_bottom[ROW_W-1:3];
      box_cmd.sprite_en  = 1'b1;
      box_cmd.sprite_col = ncol_ff - COL_W'(4);
      box_cmd.sprite_row = nrow_ff - ROW_W'(4);

      // whole frame, background only
      clr_cmd.left       = '0;
      clr_cmd.right      = COL_W'(tbso_pkg::DISPLAY_COLS - 1);
      clr_cmd.first_page = '0;
      clr_cmd.last_page  = PAGE_W'(tbso_pkg::DISPLAY_PAGES - 1);
      clr_cmd.sprite_en  = 1'b0;
      clr_cmd.sprite_col = '0;
      clr_cmd.sprite_row = '0;
   end

   assign sweep_start = (state_ff == ST_CLR_GO) || (state_ff == ST_BOX && redraw_ff);
   assign sweep_cmd   = (state_ff == ST_CLR_GO) ? clr_cmd : box_cmd;
   assign sweep_state = (state_ff == ST_SWEEP) || (state_ff == ST_CLR_RUN);

   tbso_sweep u_sweep (
      .clock (clock),
      .reset (reset),
      .start (sweep_start),
      .cmd   (sweep_cmd),
      .stat  (sweep_stat),
      .wr    (ram_wr)
   );

   // frame byte read goes out in the accept cycle
   assign ram_rd_en   = req_fire && req_tuser;
   assign ram_rd_addr = tbso_pkg::frame_addr(COL_W'(f_col), PAGE_W'(f_page));

   tbso_ram #(
      .WIDTH (8),
      .DEPTH (tbso_pkg::FRAME_BYTES)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR_GO:  state_in = ST_CLR_RUN;
         ST_CLR_RUN: if (sweep_stat.done) state_in = ST_IDLE;
         ST_IDLE:    if (req_fire) state_in = req_tuser ? ST_READ : ST_MAP;
         ST_READ:    state_in = ST_DONE;
         ST_MAP:     state_in = ST_BOX;
         ST_BOX:     state_in = redraw_ff ? ST_SWEEP : ST_DONE;
         ST_SWEEP:   if (sweep_stat.done) state_in = ST_DONE;
         ST_DONE:    if (rsp_load) state_in = ST_IDLE;
         default:    state_in = ST_CLR_GO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR_GO;
         bubble_col_ff <= COL_W'(64);
         bubble_row_ff <= ROW_W'(32);
         last_tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SWEEP && sweep_stat.done) begin
            bubble_col_ff <= ncol_ff;
            bubble_row_ff <= nrow_ff;
            last_tick_ff  <= now_ff;
         end
      end
   end

   // item capture and result assembly
   always_ff @(posedge clock) begin
      if (req_fire) begin
         tilt_x_ff <= f_tilt_x;
         tilt_y_ff <= f_tilt_y;
         zero_x_ff <= f_zero_x;
         zero_y_ff <= f_zero_y;
         now_ff    <= f_now;
         rd_hit_ff <= (32'(f_col) < tbso_pkg::DISPLAY_COLS) &&
                      (32'(f_page) < tbso_pkg::DISPLAY_PAGES);
      end
      if (state_ff == ST_MAP) begin
         ncol_ff   <= map_col;
         nrow_ff   <= map_row;
         redraw_ff <= (elapsed >= {16'd0, refresh_interval_ff});
      end
      if (state_ff == ST_READ) begin
         res_redrawn_ff <= 1'b0;
         res_col_ff     <= '0;
         res_width_ff   <= '0;
         res_first_ff   <= '0;
         res_last_ff    <= '0;
         res_byte_ff    <= rd_hit_ff ? ram_rd_data : 8'h00;
      end
      if (state_ff == ST_BOX) begin
         // no redraw reports all zero
         res_redrawn_ff <= redraw_ff;
         res_col_ff     <= redraw_ff ? 7'(box_left) : 7'd0;
         res_width_ff   <= redraw_ff ? 8'(box_width) : 8'd0;
         res_first_ff   <= redraw_ff ? 3'(box_cmd.first_page) : 3'd0;
         res_last_ff    <= redraw_ff ? 3'(box_cmd.last_page) : 3'd0;
         res_byte_ff    <= 8'h00;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_redrawn_ff <= res_redrawn_ff;
         rsp_data_ff    <= {res_byte_ff, res_last_ff, res_first_ff,
                            res_width_ff, res_col_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_redrawn_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   // checks
   `ASSERT_NEVER(a_no_accept_in_sweep, req_tready && sweep_stat.busy, "accept during a sweep")
   `ASSERT_CLK(a_write_only_in_sweep, ram_wr.en |-> sweep_state, "frame write outside a sweep")
   `ASSERT_CLK(a_done_only_in_sweep, sweep_stat.done |-> sweep_state, "sweep done in wrong state")
   `ASSERT_CLK(a_rsp_from_done, $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE), "stray response")

endmodule

// ===== tb/tilt_bubble_sprite_overlay_tb.sv =====
// self-checking testbench for the tilt bubble sprite overlay
// holds its own bubble/frame predictor in a small scoreboard class
// depends on the rtl top level tilt_bubble_sprite_overlay only
`timescale 1ns / 100ps

module tilt_bubble_sprite_overlay_tb;

   // screen geometry and bubble limits as the block sees them
   localparam int SCREEN_COLS  = 128;
   localparam int SCREEN_PAGES = 8;
   localparam int SCREEN_ROWS  = SCREEN_PAGES * 8;
   localparam int ANGLE_MAX    = 46080;       // 180 degrees in q8.8
   localparam int WALK_MAX     = 9000;        // drift range of the random tilt walk
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int LONG_HOLD    = 600;         // receiver hold-off for the pressure test

   // round bubble, one byte per column, bit n is row n of the 8x8 box
   localparam bit [7:0] BUBBLE_MASK [8] = '{
      8'h3C, 8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E, 8'h3C
   };

   localparam bit FUNC_UPDATE = 1'b0;
   localparam bit FUNC_READ   = 1'b1;

   typedef struct {
      bit               func;
      bit signed [16:0] tilt_x;
      bit signed [16:0] tilt_y;
      bit signed [16:0] zero_x;
      bit signed [16:0] zero_y;
      bit [31:0]        now_tick;
      bit [6:0]         read_column;
      bit [2:0]         read_page;
   } tilt_req_type;

   typedef struct {
      logic       redrawn;
      logic [6:0] dirty_column;
      logic [7:0] dirty_width;
      logic [2:0] dirty_first_page;
      logic [2:0] dirty_last_page;
      logic [7:0] frame_byte;
   } overlay_rsp_type;

   // mirror of the frame store and bubble state, plus the words still owed by the block
   class overlay_scoreboard;
      bit [7:0]        frame [SCREEN_COLS * SCREEN_PAGES];
      int              bubble_col;
      int              bubble_row;
      bit [31:0]       last_redraw;
      bit [15:0]       interval;
      overlay_rsp_type responses_due [$];
      int              mismatches;

      function new();
         for (int p = 0; p < SCREEN_PAGES; p++)
            for (int c = 0; c < SCREEN_COLS; c++)
               frame[p * SCREEN_COLS + c] = crosshair_byte(c, p);
         bubble_col  = 64;
         bubble_row  = 32;
         last_redraw = '0;
         interval    = 16'd30;
         mismatches  = 0;
      endfunction

      // background: row rows/2 lit across, column cols/2 lit down
      function bit [7:0] crosshair_byte(int c, int p);
         bit [7:0] b;
         b = '0;
         if (c == SCREEN_COLS / 2)
            b = 8'hFF;
         if (p == (SCREEN_ROWS / 2) / 8)
            b = b | (8'h01 << ((SCREEN_ROWS / 2) % 8));
         return b;
      endfunction

      function void set_interval(bit [15:0] v);
         interval = v;
      endfunction

      function int pending();
         return responses_due.size();
      endfunction

      // advance the predicted state by one accepted word and queue its response
      function void note_request(tilt_req_type r);
         overlay_rsp_type e;
         int              dx, dy, tx, ty, ncol, nrow;
         int              left, right, top, bottom;
         bit [31:0]       elapsed;
         e = '{default: '0};
         if (r.func == FUNC_READ) begin
            e.frame_byte = frame[int'(r.read_page) * SCREEN_COLS + int'(r.read_column)];
         end else begin
            dx = int'(r.tilt_x) - int'(r.zero_x);
            dy = int'(r.tilt_y) - int'(r.zero_y);
            tx = (SCREEN_COLS / 2) * 256 + 2 * dx;
            ty = (SCREEN_ROWS / 2) * 256 - 2 * dy;
            if (tx < 4 * 256) tx = 4 * 256;
            if (tx > (SCREEN_COLS - 5) * 256) tx = (SCREEN_COLS - 5) * 256;
            if (ty < 4 * 256) ty = 4 * 256;
            if (ty > (SCREEN_ROWS - 5) * 256) ty = (SCREEN_ROWS - 5) * 256;
            ncol = tx >>> 8;
            nrow = ty >>> 8;
            elapsed = r.now_tick - last_redraw;
            if (elapsed >= {16'd0, interval}) begin
               // union of old and new 8x8 boxes
               left   = (bubble_col < ncol ? bubble_col : ncol) - 4;
               top    = (bubble_row < nrow ? bubble_row : nrow) - 4;
               right  = (bubble_col > ncol ? bubble_col : ncol) + 3;
               bottom = (bubble_row > nrow ? bubble_row : nrow) + 3;
               if (right > SCREEN_COLS - 1)
                  right = SCREEN_COLS - 1;
               for (int p = top >> 3; p <= (bottom >> 3) && p < SCREEN_PAGES; p++)
                  for (int c = left; c <= right; c++)
                     frame[p * SCREEN_COLS + c] = crosshair_byte(c, p);
               for (int i = 0; i < 8; i++)
                  for (int j = 0; j < 8; j++)
                     if (BUBBLE_MASK[i][j])
                        frame[((nrow + j - 4) >> 3) * SCREEN_COLS + ncol + i - 4] |=
                           8'h01 << ((nrow + j - 4) & 7);
               bubble_col  = ncol;
               bubble_row  = nrow;
               last_redraw = r.now_tick;
               e.redrawn          = 1'b1;
               e.dirty_column     = left[6:0];
               e.dirty_width      = 8'(right - left + 1);
               e.dirty_first_page = 3'(top >> 3);
               e.dirty_last_page  = 3'(bottom >> 3);
            end
         end
         responses_due.push_back(e);
      endfunction

      function void report_field(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, want, got);
      endfunction

      function void check_response(overlay_rsp_type got);
         overlay_rsp_type e;
         if (responses_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response word with nothing outstanding", $realtime);
         end else begin
            e = responses_due.pop_front();
            if (got.redrawn !== e.redrawn)
               report_field("redrawn", 32'(e.redrawn), 32'(got.redrawn));
            if (got.dirty_column !== e.dirty_column)
               report_field("dirty_column", 32'(e.dirty_column), 32'(got.dirty_column));
            if (got.dirty_width !== e.dirty_width)
               report_field("dirty_width", 32'(e.dirty_width), 32'(got.dirty_width));
            if (got.dirty_first_page !== e.dirty_first_page)
               report_field("dirty_first_page", 32'(e.dirty_first_page),
                            32'(got.dirty_first_page));
            if (got.dirty_last_page !== e.dirty_last_page)
               report_field("dirty_last_page", 32'(e.dirty_last_page),
                            32'(got.dirty_last_page));
            if (got.frame_byte !== e.frame_byte)
               report_field("frame_byte", 32'(e.frame_byte), 32'(got.frame_byte));
         end
      endfunction
   endclass

   // dut ports; the inputs are all known from time zero
   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data   = '0;

   overlay_scoreboard board;

   // idling switches, per phase
   bit          sender_gaps_on;
   bit          receiver_stalls_on;
   int          hold_request;        // long receiver hold-off, picked up by the receiver
   bit [31:0]   tick_now;            // running tick for well-formed update streams
   int          walk_x, walk_y;      // slow tilt drift keeps most dirty boxes small
   int          cycle_count;

   tilt_bubble_sprite_overlay dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int random_angle();
      return int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
   endfunction

   function automatic tilt_req_type make_update(int tx, int ty, int zx, int zy, bit [31:0] tick);
      tilt_req_type r;
      r = '{default: '0};
      r.func     = FUNC_UPDATE;
      r.tilt_x   = 17'(tx);
      r.tilt_y   = 17'(ty);
      r.zero_x   = 17'(zx);
      r.zero_y   = 17'(zy);
      r.now_tick = tick;
      return r;
   endfunction

   function automatic tilt_req_type make_read(int col, int page);
      tilt_req_type r;
      r = '{default: '0};
      r.func        = FUNC_READ;
      r.read_column = 7'(col);
      r.read_page   = 3'(page);
      return r;
   endfunction

   // mostly a drifting tilt with advancing ticks, now and then a full random jump
   function automatic tilt_req_type random_request();
      tilt_req_type r;
      int           zspan;
      zspan         = ANGLE_MAX - WALK_MAX;
      r.func        = ($urandom_range(0, 99) < 40) ? FUNC_READ : FUNC_UPDATE;
      r.read_column = 7'($urandom_range(0, SCREEN_COLS - 1));
      r.read_page   = 3'($urandom_range(0, SCREEN_PAGES - 1));
      r.now_tick    = $urandom();
      if ($urandom_range(0, 7) == 0) begin
         r.tilt_x = 17'(random_angle());
         r.tilt_y = 17'(random_angle());
         r.zero_x = 17'(random_angle());
         r.zero_y = 17'(random_angle());
      end else begin
         walk_x = walk_x + int'($urandom_range(0, 1200)) - 600;
         walk_y = walk_y + int'($urandom_range(0, 1200)) - 600;
         if (walk_x > WALK_MAX) walk_x = WALK_MAX;
         if (walk_x < -WALK_MAX) walk_x = -WALK_MAX;
         if (walk_y > WALK_MAX) walk_y = WALK_MAX;
         if (walk_y < -WALK_MAX) walk_y = -WALK_MAX;
         r.zero_x = 17'(int'($urandom_range(0, 2 * zspan)) - zspan);
         r.zero_y = 17'(int'($urandom_range(0, 2 * zspan)) - zspan);
         r.tilt_x = 17'(int'(r.zero_x) + walk_x);
         r.tilt_y = 17'(int'(r.zero_y) + walk_y);
      end
      if (r.func == FUNC_READ) begin
         // half the reads land on or around the bubble
         if ($urandom_range(0, 1) == 1) begin
            r.read_column = 7'(board.bubble_col + int'($urandom_range(0, 11)) - 6);
            r.read_page   = 3'((board.bubble_row >> 3) + int'($urandom_range(0, 2)) - 1);
         end
      end else if ($urandom_range(0, 7) != 0) begin
         // step the tick around the refresh interval so both outcomes happen
         tick_now   = tick_now + $urandom_range(0, 2 * int'(board.interval) + 2);
         r.now_tick = tick_now;
      end else begin
         tick_now = r.now_tick;
      end
      return r;
   endfunction

   // offer one word, optionally after a gap, and hold it until taken
   task automatic send_request(tilt_req_type r);
      if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.func;
      req_tdata  <= {2'b00, r.read_page, r.read_column, r.now_tick,
                     r.zero_y, r.zero_x, r.tilt_y, r.tilt_x};
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      board.note_request(r);
   endtask

   task automatic run_random(int count);
      for (int n = 0; n < count; n++)
         send_request(random_request());
   endtask

   // block is idle once every owed word has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_interval(bit [15:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      board.set_interval(v);
      csr_valid <= 1'b0;
   endtask

   // receiver: checks each taken word, then picks next cycle's ready
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            board.check_response('{rsp_tuser, rsp_tdata[6:0], rsp_tdata[14:7],
                                   rsp_tdata[17:15], rsp_tdata[20:18], rsp_tdata[28:21]});
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      board              = new();
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      hold_request       = 0;
      tick_now           = '0;
      walk_x             = 0;
      walk_y             = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // the clearing pass after reset is covered by waiting on req_tready

      // directed part, reset interval of 30
      send_request(make_read(64, 4));          // crosshair center, full byte
      send_request(make_read(0, 4));           // horizontal line only
      send_request(make_read(64, 0));          // vertical line only
      send_request(make_read(127, 7));         // far corner, blank
      send_request(make_read(0, 0));
      send_request(make_update(0, 0, 0, 0, 32'd10));                 // too soon, no redraw
      send_request(make_update(ANGLE_MAX, ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX,
                               32'd30));                             // clamp right / top
      send_request(make_read(123, 0));
      send_request(make_read(119, 0));
      send_request(make_update(-ANGLE_MAX, -ANGLE_MAX, ANGLE_MAX, ANGLE_MAX,
                               32'd60));                             // clamp left / bottom, widest box
      send_request(make_read(0, 7));
      send_request(make_read(4, 7));
      send_request(make_update(0, 0, 0, 0, 32'hFFFF_FFF0));         // back to center
      send_request(make_update(100, -100, 0, 0, 32'h0000_000D));     // wrapped elapsed just short
      send_request(make_update(384, -384, 0, 0, 32'h0000_000E));     // wrapped elapsed exactly equal
      send_request(make_update(255, 0, 0, 0, 32'hFFFF_FFFF));        // center truncates down
      send_request(make_read(65, 4));
      send_request(make_read(64, 3));
      send_request(make_update(-ANGLE_MAX, ANGLE_MAX, -ANGLE_MAX, ANGLE_MAX,
                               32'hFFFF_FFFF));                      // zero elapsed, no redraw
      wait_idle();

      // interval 0: every update redraws, even at zero elapsed
      write_interval(16'd0);
      send_request(make_update(-ANGLE_MAX, ANGLE_MAX, -ANGLE_MAX, ANGLE_MAX,
                               32'hFFFF_FFFF));
      send_request(make_update(1, -1, 0, 0, 32'd0));                 // same spot redraw
      send_request(make_read(127, 7));
      run_random(140);
      wait_idle();

      // longest interval, receiver never stalls here
      receiver_stalls_on = 1'b0;
      write_interval(16'hFFFF);
      run_random(100);
      wait_idle();

      // middle interval with a long receiver hold so the block backs up
      receiver_stalls_on = 1'b1;
      write_interval(16'($urandom_range(1, 300)));
      run_random(20);
      hold_request = LONG_HOLD;
      run_random(140);
      wait_idle();

      // last stretch with no idling on either side
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      write_interval(16'($urandom_range(0, 64)));
      run_random(130);
      wait_idle();

      // allow for any stray word after the last expected one
      repeat (1100) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/tbso_pkg.sv
src/tbso_ram.sv
src/tbso_tilt_map.sv
src/tbso_sweep.sv
src/tilt_bubble_sprite_overlay.sv
tb/tilt_bubble_sprite_overlay_tb.sv
